>>> src/lsq_pkg.sv
// shared constants and types for the least-squares line evaluator
package lsq_pkg;

  localparam int MaxPointsDefault = 1024;
  localparam int CoordW = 24;
  localparam int SumW = 35;
  localparam int SqW = 58;
  localparam int FitW = 32;
  localparam int StatW = 2;
  localparam int WideW = 128;
  localparam int CfgIdxW = 1;
  localparam int QueueDepth = 2;

  localparam logic [StatW-1:0] StatOk = 2'd0;
  localparam logic [StatW-1:0] StatDegen = 2'd1;
  localparam logic [StatW-1:0] StatOver = 2'd2;

  localparam logic [CfgIdxW-1:0] RegEvalPoint = 1'd0;
  localparam logic [CfgIdxW-1:0] RegEvalAtLast = 1'd1;

  // one closed run handed from the accumulator to the solver
  typedef struct packed {
    logic [10:0] count;
    logic signed [SumW-1:0] sx;
    logic signed [SumW-1:0] sy;
    logic signed [SqW-1:0] sxx;
    logic signed [SqW-1:0] sxy;
    logic signed [CoordW-1:0] lastx;
    logic over;
  } run_t;

endpackage

>>> src/lsq_ram.sv
// generic single-port-write, registered-read memory
module lsq_ram #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> src/lsq_front.sv
// accumulates points of a run and pushes closed runs into the queue
module lsq_front import lsq_pkg::*; #(
  parameter int MaxPoints = MaxPointsDefault
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     take,
  input  logic signed [CoordW-1:0] x_value,
  input  logic signed [CoordW-1:0] y_value,
  input  logic                     last_point,
  output logic                     push,
  output run_t                     run
);
  logic [10:0] count;
  logic signed [SumW-1:0] sx, sy;
  logic signed [SqW-1:0] sxx, sxy;
  logic signed [CoordW-1:0] lastx;
  logic over;
  logic room;
  logic signed [2*CoordW-1:0] pxx, pxy;
  logic [10:0] count_next;
  logic signed [SumW-1:0] sx_next, sy_next;
  logic signed [SqW-1:0] sxx_next, sxy_next;
  logic signed [CoordW-1:0] lastx_next;

  assign room = count < 11'(MaxPoints);
  assign pxx = x_value * x_value;
  assign pxy = x_value * y_value;

  always_comb begin
    count_next = count;
    sx_next = sx;
    sy_next = sy;
    sxx_next = sxx;
    sxy_next = sxy;
    lastx_next = lastx;
    if (room) begin
      count_next = count + 11'd1;
      sx_next = sx + SumW'(x_value);
      sy_next = sy + SumW'(y_value);
      sxx_next = sxx + SqW'(pxx);
      sxy_next = sxy + SqW'(pxy);
      lastx_next = x_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      sx <= '0;
      sy <= '0;
      sxx <= '0;
      sxy <= '0;
      lastx <= '0;
      over <= 1'b0;
      push <= 1'b0;
    end else begin
      push <= take && last_point;
      if (take) begin
        run <= '{count_next, sx_next, sy_next, sxx_next, sxy_next, lastx_next,
                 over | ~room};
        if (last_point) begin
          count <= '0;
          sx <= '0;
          sy <= '0;
          sxx <= '0;
          sxy <= '0;
          lastx <= '0;
          over <= 1'b0;
        end else begin
          count <= count_next;
          sx <= sx_next;
          sy <= sy_next;
          sxx <= sxx_next;
          sxy <= sxy_next;
          lastx <= lastx_next;
          over <= over | ~room;
        end
      end
    end
  end
endmodule

>>> src/lsq_queue.sv
// short queue of closed runs between accumulator and solver
module lsq_queue import lsq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  run_t wdata,
  input  logic pop,
  output logic not_empty,
  output logic full,
  output run_t rdata
);
  localparam int AW = $clog2(QueueDepth);
  logic [AW-1:0] wp, rp;
  logic [AW:0] fill;
  logic [AW-1:0] rp_next;
  logic [AW:0] fill_next;

  // registered read: address the next head so data is ready when it shows
  assign rp_next = pop ? rp + 1'b1 : rp;
  assign fill_next = fill + (AW+1)'(push) - (AW+1)'(pop);

  lsq_ram #(.Width($bits(run_t)), .Depth(QueueDepth)) u_ram (
    .clk(clk), .we(push), .waddr(wp), .wdata(wdata),
    .raddr(rp_next), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      fill <= '0;
      not_empty <= 1'b0;
    end else begin
      if (push) wp <= wp + 1'b1;
      rp <= rp_next;
      fill <= fill_next;
      // a write becomes readable the cycle after it lands
      not_empty <= (fill_next != '0) && !(push && fill == '0 && !pop) &&
                   !(push && pop && fill == (AW+1)'(1));
    end
  end
  assign full = fill >= (AW+1)'(QueueDepth - 1);
endmodule

>>> src/lsq_solve.sv
// multi-cycle solver: products over a shared 32x32 multiplier, then long division
module lsq_solve import lsq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     go,
  input  run_t                     run,
  input  logic signed [CoordW-1:0] eval_point,
  input  logic                     eval_at_last_x,
  output logic                     busy,
  output logic                     done,
  output logic signed [FitW-1:0]   fit_value,
  output logic [StatW-1:0]         status
);
  localparam logic [3:0] S_IDLE = 4'd0, S_D1 = 4'd1, S_D2 = 4'd2, S_A1 = 4'd3,
                         S_A2 = 4'd4, S_E = 4'd5, S_N1 = 4'd6, S_N2 = 4'd7,
                         S_DEN = 4'd8, S_PREP = 4'd9, S_DIV = 4'd10,
                         S_SAT = 4'd11, S_OUT = 4'd12;
  logic [3:0] state;
  run_t r;
  logic signed [WideW-1:0] d, a, e, num, t, dif;
  logic [WideW-1:0] mag, dvd, dvs, rem, quo, rem_s, rem_n;
  logic ge, neg;
  logic [6:0] bitn;

  // shared multiplier: 16 limb products of 32x32, summed modulo 2^128
  logic [WideW-1:0] ma, mb;
  logic signed [WideW-1:0] macc;
  logic [3:0] mstep;
  logic mbusy;
  logic [31:0] limb_a, limb_b;
  logic [63:0] pp;
  logic [2:0] lsum;
  logic [WideW-1:0] pp_sh;

  assign limb_a = ma[32*mstep[3:2] +: 32];
  assign limb_b = mb[32*mstep[1:0] +: 32];
  assign pp = {32'd0, limb_a} * {32'd0, limb_b};
  // limb weight; products that land at or above bit 128 drop out
  assign lsum = {1'b0, mstep[3:2]} + {1'b0, mstep[1:0]};
  assign pp_sh = {64'd0, pp} << {lsum, 5'd0};

  assign dif = t - macc;
  assign mag = num[WideW-1] ? -num : num;

  // restoring division step
  assign rem_s = {rem[WideW-2:0], dvd[WideW-1]};
  assign ge = rem_s >= dvs;
  assign rem_n = ge ? rem_s - dvs : rem_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      mbusy <= 1'b0;
    end else begin
      done <= 1'b0;
      if (mbusy) begin
        macc <= macc + pp_sh;
        if (mstep == 4'd15) begin
          mbusy <= 1'b0;
        end
        mstep <= mstep + 4'd1;
      end else begin
        case (state)
          S_IDLE: if (go) begin
            r <= run;
            state <= S_D1;
          end
          S_D1: begin
            if (r.count < 11'd2) begin
              fit_value <= '0;
              status <= r.over ? StatOver : StatDegen;
              state <= S_OUT;
            end else begin
              ma <= WideW'(r.count); mb <= WideW'(r.sxx);
              macc <= '0; mstep <= '0; mbusy <= 1'b1; state <= S_D2;
            end
          end
          S_D2: begin
            t <= macc;
            ma <= WideW'(r.sx); mb <= WideW'(r.sx);
            macc <= '0; mstep <= '0; mbusy <= 1'b1; state <= S_A1;
          end
          S_A1: begin
            d <= dif;
            if (dif[WideW-1] || dif == '0) begin
              fit_value <= '0;
              status <= r.over ? StatOver : StatDegen;
              state <= S_OUT;
            end else begin
              ma <= WideW'(r.count); mb <= WideW'(r.sxy);
              macc <= '0; mstep <= '0; mbusy <= 1'b1; state <= S_A2;
            end
          end
          S_A2: begin
            t <= macc;
            ma <= WideW'(r.sx); mb <= WideW'(r.sy);
            macc <= '0; mstep <= '0; mbusy <= 1'b1; state <= S_E;
          end
          S_E: begin
            a <= dif;
            ma <= WideW'(r.count);
            mb <= WideW'(eval_at_last_x ? r.lastx : eval_point);
            macc <= '0; mstep <= '0; mbusy <= 1'b1; state <= S_N1;
          end
          S_N1: begin
            e <= macc - WideW'(r.sx);
            ma <= WideW'(r.sy); mb <= d;
            macc <= '0; mstep <= '0; mbusy <= 1'b1; state <= S_N2;
          end
          S_N2: begin
            t <= macc;
            ma <= a; mb <= e;
            macc <= '0; mstep <= '0; mbusy <= 1'b1; state <= S_DEN;
          end
          S_DEN: begin
            num <= t + macc;
            ma <= WideW'(r.count); mb <= d;
            macc <= '0; mstep <= '0; mbusy <= 1'b1; state <= S_PREP;
          end
          S_PREP: begin
            // round half away from zero: (2|num| + den) / (2 den)
            neg <= num[WideW-1];
            dvd <= (mag << 1) + macc;
            dvs <= macc << 1;
            rem <= '0;
            quo <= '0;
            bitn <= '0;
            state <= S_DIV;
          end
          S_DIV: begin
            rem <= rem_n;
            quo <= {quo[WideW-2:0], ge};
            dvd <= dvd << 1;
            bitn <= bitn + 7'd1;
            if (bitn == 7'd127) begin
              state <= S_SAT;
            end
          end
          S_SAT: begin
            status <= r.over ? StatOver : StatOk;
            if (neg) begin
              fit_value <= (quo > 128'h8000_0000) ? {1'b1, 31'd0} : FitW'(-quo);
            end else begin
              fit_value <= (quo > 128'h7fff_ffff) ? {1'b0, {31{1'b1}}} : FitW'(quo);
            end
            state <= S_OUT;
          end
          S_OUT: begin
            done <= 1'b1;
            state <= S_IDLE;
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  assign busy = (state != S_IDLE);
endmodule

>>> src/least_squares_line_eval.sv
// top level of the least-squares line evaluator
// usage:
//   raise start with x_value, y_value, last_point while busy is low; one point
//   transfers per cycle. points past MaxPoints are dropped and flagged.
//   the point with last_point closes the run: its sums go into a two-entry
//   queue and the solver forms D, A and the numerator on a shared 32x32
//   multiplier (8 products), then runs a 128-step restoring division.
//   fit_value and status show for one cycle with result_valid high once the
//   solver finishes the run; a run of fewer than two points answers without
//   any product, and a zero denominator after the first two products.
//   the solver takes a new run only when it is idle. busy is high while a
//   closed run waits in the queue, so points stall until the solver picks it
//   up.
//   configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; writes are
//   always taken and belong only where no run is in flight.
//   index 0 is eval_point, index 1 is eval_at_last_x.
//   reset (rst, synchronous) clears the sums, queue pointers, solver state and configuration registers.
//   the receiver cannot stall: each result is a single-cycle transfer.
module least_squares_line_eval import lsq_pkg::*; #(
  parameter int MaxPoints = MaxPointsDefault
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [CoordW-1:0] x_value,
  input  logic signed [CoordW-1:0] y_value,
  input  logic                     last_point,
  output logic                     result_valid,
  output logic signed [FitW-1:0]   fit_value,
  output logic [StatW-1:0]         status,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CfgIdxW-1:0]       cfg_index,
  input  logic [CoordW-1:0]        cfg_data
);
  logic signed [CoordW-1:0] eval_point;
  logic eval_at_last_x;
  logic take, push, not_empty, full, sbusy, pop;
  run_t run_in, run_out;

  assign cfg_ready = 1'b1;
  assign take = start && !busy;
  // keep a slot free for the run pushed the cycle after the take
  assign busy = full;
  assign pop = not_empty && !sbusy;

  always_ff @(posedge clk) begin
    if (rst) begin
      eval_point <= '0;
      eval_at_last_x <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegEvalPoint: eval_point <= cfg_data;
        RegEvalAtLast: eval_at_last_x <= cfg_data[0];
        default: ;
      endcase
    end
  end

  lsq_front #(.MaxPoints(MaxPoints)) u_front (
    .clk(clk), .rst(rst), .take(take), .x_value(x_value), .y_value(y_value),
    .last_point(last_point), .push(push), .run(run_in)
  );

  lsq_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .wdata(run_in), .pop(pop),
    .not_empty(not_empty), .full(full), .rdata(run_out)
  );

  lsq_solve u_solve (
    .clk(clk), .rst(rst), .go(pop), .run(run_out), .eval_point(eval_point),
    .eval_at_last_x(eval_at_last_x), .busy(sbusy), .done(result_valid),
    .fit_value(fit_value), .status(status)
  );
endmodule
